[rtl/oafr_pkg.sv]
// Shared types and constants for the overlapped audio frame ring.
`timescale 1ns / 1ps
`default_nettype none
package oafr_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 13;
	localparam int LEVEL_W  = 13;
	localparam int TOTAL_W  = 32;
	localparam int CIDX_W   = 2;
	localparam int CDATA_W  = 16;

	localparam logic [CFG_W-1:0] FRAME_SIZE_RST  = 13'd400;
	localparam logic [CFG_W-1:0] FRAME_SHIFT_RST = 13'd160;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_FLUSH = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_OVERRUN = 2'd1,
		STAT_PAD     = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		REG_FRAME_SIZE   = 2'd0,
		REG_FRAME_SHIFT  = 2'd1,
		REG_SILENCE_FILL = 2'd2,
		REG_PAD_VALUE    = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_EMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic sweep_load;
		logic sweep_step;
		logic commit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sweep_done;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

[rtl/oafr_ifs.sv]
// Valid/ready channel interfaces for items, results and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface oafr_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [15:0] sample;

	modport source (output valid, output mode, output sample, input ready);
	modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface oafr_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic               frame_last;
	logic [1:0]         status;
	logic [12:0]        fill_level;
	logic [31:0]        written_total;
	logic [31:0]        consumed_total;

	modport source (output valid, output sample_out, output frame_last, output status,
		output fill_level, output written_total, output consumed_total, input ready);
	modport sink   (input valid, input sample_out, input frame_last, input status,
		input fill_level, input written_total, input consumed_total, output ready);
endinterface

interface oafr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/oafr_ram.sv]
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module oafr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

[rtl/oafr_dp.sv]
// Datapath: ring storage, pointers, counts, totals, registers and result register.
`timescale 1ns / 1ps
`default_nettype none
module oafr_dp #(
	parameter int RING_DEPTH = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire oafr_pkg::dp_cmd_t             cmd,
	output oafr_pkg::dp_sts_t                  sts,
	input  wire logic [1:0]                    item_mode,
	input  wire logic signed [15:0]            item_sample,
	input  wire logic                          cfg_valid,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [15:0]                   cfg_data,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output logic signed [15:0]                 res_sample_out,
	output logic                               res_frame_last,
	output logic [1:0]                         res_status,
	output logic [12:0]                        res_fill_level,
	output logic [31:0]                        res_written_total,
	output logic [31:0]                        res_consumed_total
);
	import oafr_pkg::*;

	localparam int IW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int SW = (CW > CFG_W) ? CW : CFG_W;
	localparam logic [SW-1:0] DEPTH_S   = SW'(RING_DEPTH);
	localparam logic [CW-1:0] DEPTH_C   = CW'(RING_DEPTH);
	localparam logic [IW-1:0] LAST_IDX  = IW'(RING_DEPTH - 1);

	// Configuration registers
	logic [CFG_W-1:0]           frame_size_q;
	logic [CFG_W-1:0]           frame_shift_q;
	logic [SAMPLE_W-1:0]        silence_fill_q;
	logic signed [SAMPLE_W-1:0] pad_value_q;

	// Ring state
	logic [IW-1:0]      wr_idx_q;
	logic [IW-1:0]      rd_idx_q;
	logic [CW-1:0]      fill_q;
	logic [IW-1:0]      pos_q;
	logic [TOTAL_W-1:0] wr_tally_q;
	logic [TOTAL_W-1:0] rd_tally_q;

	// Captured transaction and sweep
	mode_t                      mode_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [IW-1:0]              sweep_cnt_q;
	logic [SAMPLE_W-1:0]        sweep_val_q;

	// Result register
	logic                       out_valid_q;

	// RAM ports
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic [SAMPLE_W-1:0] ram_wdata;
	logic [IW-1:0]       ram_raddr;
	logic [SAMPLE_W-1:0] ram_rdata;

	// Effective frame size and shift
	logic [SW-1:0] fs_w, fh_w, sz_w, sh_w;
	logic [CW-1:0] size_eff, shift_eff;

	// Next-state values
	logic [IW:0]          rd_sum;
	logic [CW:0]          adv_sum;
	logic [CW-1:0]        pos_inc;
	logic [CW-1:0]        used;
	logic                 last;
	logic                 pad;
	logic [IW-1:0]        wr_idx_nxt, rd_idx_nxt, pos_nxt;
	logic [CW-1:0]        fill_nxt;
	logic [TOTAL_W-1:0]   wr_tally_nxt, rd_tally_nxt;
	logic signed [SAMPLE_W-1:0] smp_nxt;
	stat_t                stat_nxt;

	// Clamp frame size to 1..depth and shift to 1..size
	always_comb begin
		fs_w = SW'(frame_size_q);
		fh_w = SW'(frame_shift_q);
		if (fs_w == '0) begin
			sz_w = SW'(1);
		end else if (fs_w > DEPTH_S) begin
			sz_w = DEPTH_S;
		end else begin
			sz_w = fs_w;
		end
		if (fh_w == '0) begin
			sh_w = SW'(1);
		end else if (fh_w > sz_w) begin
			sh_w = sz_w;
		end else begin
			sh_w = fh_w;
		end
		size_eff  = CW'(sz_w);
		shift_eff = CW'(sh_w);
	end

	// Frame sample address: read pointer plus frame offset, wrapped
	always_comb begin
		rd_sum = (IW+1)'(rd_idx_q) + (IW+1)'(pos_q);
		if (rd_sum >= (IW+1)'(RING_DEPTH)) begin
			rd_sum = rd_sum - (IW+1)'(RING_DEPTH);
		end
		ram_raddr = rd_sum[IW-1:0];
	end

	// Compute the committed state and result for the captured transaction
	always_comb begin
		wr_idx_nxt   = wr_idx_q;
		rd_idx_nxt   = rd_idx_q;
		pos_nxt      = pos_q;
		fill_nxt     = fill_q;
		wr_tally_nxt = wr_tally_q;
		rd_tally_nxt = rd_tally_q;
		smp_nxt      = '0;
		stat_nxt     = STAT_OK;
		last         = 1'b0;
		pad          = (mode_q == MODE_FLUSH) && (CW'(pos_q) >= fill_q);
		pos_inc      = CW'(pos_q) + CW'(1);
		used         = (mode_q == MODE_READ) ? shift_eff
			: ((fill_q < size_eff) ? fill_q : size_eff);
		adv_sum      = (CW+1)'(rd_idx_q) + (CW+1)'(used);
		if (adv_sum >= (CW+1)'(RING_DEPTH)) begin
			adv_sum = adv_sum - (CW+1)'(RING_DEPTH);
		end
		unique case (mode_q)
			MODE_WRITE: begin
				wr_idx_nxt   = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + IW'(1);
				wr_tally_nxt = wr_tally_q + TOTAL_W'(1);
				if (fill_q >= DEPTH_C) begin
					fill_nxt = DEPTH_C;
					stat_nxt = STAT_OVERRUN;
				end else begin
					fill_nxt = fill_q + CW'(1);
				end
			end
			MODE_READ, MODE_FLUSH: begin
				if (pad) begin
					smp_nxt  = pad_value_q;
					stat_nxt = STAT_PAD;
				end else begin
					smp_nxt  = $signed(ram_rdata);
				end
				pos_nxt = IW'(pos_inc);
				if (pos_inc >= size_eff) begin
					last         = 1'b1;
					pos_nxt      = '0;
					rd_tally_nxt = rd_tally_q + TOTAL_W'(used);
					rd_idx_nxt   = IW'(adv_sum);
					fill_nxt     = (fill_q > used) ? fill_q - used : '0;
				end
			end
			MODE_CLEAR: begin
				wr_idx_nxt   = '0;
				rd_idx_nxt   = '0;
				pos_nxt      = '0;
				fill_nxt     = '0;
				wr_tally_nxt = '0;
				rd_tally_nxt = '0;
			end
		endcase
	end

	// RAM write port: sweep or sample store
	always_comb begin
		if (cmd.sweep_step) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_cnt_q;
			ram_wdata = sweep_val_q;
		end else begin
			ram_we    = cmd.commit && (mode_q == MODE_WRITE);
			ram_waddr = wr_idx_q;
			ram_wdata = sample_q;
		end
	end

	oafr_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.capture),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_size_q   <= FRAME_SIZE_RST;
			frame_shift_q  <= FRAME_SHIFT_RST;
			silence_fill_q <= '0;
			pad_value_q    <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FRAME_SIZE:   frame_size_q   <= cfg_data[CFG_W-1:0];
				REG_FRAME_SHIFT:  frame_shift_q  <= cfg_data[CFG_W-1:0];
				REG_SILENCE_FILL: silence_fill_q <= cfg_data;
				REG_PAD_VALUE:    pad_value_q    <= $signed(cfg_data);
			endcase
		end
	end

	// Capture the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= mode_t'(item_mode);
			sample_q <= item_sample;
		end
	end

	// Sweep counter and fill value; reset sweep writes zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
			sweep_val_q <= '0;
		end else if (cmd.sweep_load) begin
			sweep_cnt_q <= '0;
			sweep_val_q <= silence_fill_q;
		end else if (cmd.sweep_step) begin
			sweep_cnt_q <= (sweep_cnt_q == LAST_IDX) ? '0 : sweep_cnt_q + IW'(1);
		end
	end

	// Commit ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			fill_q     <= '0;
			pos_q      <= '0;
			wr_tally_q <= '0;
			rd_tally_q <= '0;
		end else if (cmd.commit) begin
			wr_idx_q   <= wr_idx_nxt;
			rd_idx_q   <= rd_idx_nxt;
			fill_q     <= fill_nxt;
			pos_q      <= pos_nxt;
			wr_tally_q <= wr_tally_nxt;
			rd_tally_q <= rd_tally_nxt;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_sample_out     <= smp_nxt;
			res_frame_last     <= last;
			res_status         <= stat_nxt;
			res_fill_level     <= LEVEL_W'(fill_nxt);
			res_written_total  <= wr_tally_nxt;
			res_consumed_total <= rd_tally_nxt;
		end
	end

	assign res_valid      = out_valid_q;
	assign sts.out_free   = !out_valid_q || res_ready;
	assign sts.sweep_done = (sweep_cnt_q == LAST_IDX);

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count above ring depth");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_idx_q <= LAST_IDX) && (rd_idx_q <= LAST_IDX))
		else $error("ring pointer out of range");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || res_ready))
		else $error("result register overwritten while held");
`endif
endmodule
`default_nettype wire

[rtl/oafr_ctrl.sv]
// Controller: sequences reset sweep, clear sweep, capture and commit.
`timescale 1ns / 1ps
`default_nettype none
module oafr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire logic [1:0]         item_mode,
	output logic                    item_ready,
	input  wire oafr_pkg::dp_sts_t  sts,
	output oafr_pkg::dp_cmd_t       cmd
);
	import oafr_pkg::*;

	state_t state_q, state_nxt;
	logic   accept;

	assign accept = (state_q == S_IDLE) && item_valid;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_INIT: begin
				if (sts.sweep_done) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (item_valid) begin
					state_nxt = (mode_t'(item_mode) == MODE_CLEAR) ? S_CLEAR : S_EMIT;
				end
			end
			S_CLEAR: begin
				if (sts.sweep_done) state_nxt = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		item_ready     = (state_q == S_IDLE);
		cmd.capture    = accept;
		cmd.sweep_load = accept && (mode_t'(item_mode) == MODE_CLEAR);
		cmd.sweep_step = (state_q == S_INIT) || (state_q == S_CLEAR);
		cmd.commit     = (state_q == S_EMIT) && sts.out_free;
	end

`ifndef SYNTHESIS
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !sts.out_free) |=> (state_q == S_EMIT))
		else $error("result dropped while output stalled");

	a_clear_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && sts.sweep_done) |=> (state_q == S_EMIT))
		else $error("clear sweep did not end in a result");
`endif
endmodule
`default_nettype wire

[rtl/overlapped_audio_frame_ring.sv]
// Top level: overlapping audio frame ring with item, result and register channels.
// A write, read or flush result enters the output register after acceptance, once that
//   register is free; the sequencer holds one item from acceptance until its result
//   enters the output register and accepts no new item before then.
// A clear sweeps every ring entry: the ring RAM write port fills one entry a cycle.
// Reset: arst_n clears control state, then a pass over every entry zeroes the ring;
//   no items are accepted during that pass, register writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module overlapped_audio_frame_ring #(
	parameter int RING_DEPTH = 4096
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	oafr_item_if.sink     item,
	oafr_result_if.source result,
	oafr_cfg_if.sink      cfg
);
	import oafr_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Register writes are always taken
	assign cfg.ready = 1'b1;

	oafr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_mode  (item.mode),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	oafr_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.item_mode          (item.mode),
		.item_sample        (item.sample),
		.cfg_valid          (cfg.valid),
		.cfg_index          (cfg.index),
		.cfg_data           (cfg.data),
		.res_valid          (result.valid),
		.res_ready          (result.ready),
		.res_sample_out     (result.sample_out),
		.res_frame_last     (result.frame_last),
		.res_status         (result.status),
		.res_fill_level     (result.fill_level),
		.res_written_total  (result.written_total),
		.res_consumed_total (result.consumed_total)
	);
endmodule
`default_nettype wire
